/* hw/rtl/bht_pkg.sv */
`timescale 1ns / 1ps

package bht_pkg;

  localparam int DEF_MAX_BACKENDS = 16;

  localparam int ACTION_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int ADDR_W    = 32;
  localparam int NB_W      = 5;
  localparam int MISSED_W  = 16;
  localparam int COUNT_W   = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD      = 3'd0,
    ACT_HEARTBEAT = 3'd1,
    ACT_TICK      = 3'd2,
    ACT_ACTIVATE  = 3'd3,
    ACT_QUERY     = 3'd4,
    ACT_SELECT    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_INITIAL = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_FAULT   = 2'd2
  } mode_t;

  typedef enum logic {
    REG_NUM_BACKENDS = 1'b0,
    REG_MAX_MISSED   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    mode_t              mode;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_out;
    logic               found;
    logic               entry_normal;
    logic               start_query;
    logic               activation_ack;
    logic               bad_index;
  } result_t;

endpackage

/* hw/rtl/bht_in_if.sv */
`timescale 1ns / 1ps

interface bht_in_if import bht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  index;
  logic [ADDR_W-1:0]   address;
  logic                message_initial;
  logic                ack_ok;

  modport source (output valid, action, index, address, message_initial, ack_ok,
                  input ready);
  modport sink (input valid, action, index, address, message_initial, ack_ok,
                output ready);
endinterface

/* hw/rtl/bht_out_if.sv */
`timescale 1ns / 1ps

interface bht_out_if import bht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index_out;
  logic               found;
  logic               entry_normal;
  logic               start_query;
  logic               activation_ack;
  logic               bad_index;

  modport source (output valid, index_out, found, entry_normal, start_query,
                  activation_ack, bad_index, input ready);
  modport sink (input valid, index_out, found, entry_normal, start_query,
                activation_ack, bad_index, output ready);
endinterface

/* hw/rtl/bht_rem.sv */
`timescale 1ns / 1ps

module bht_rem import bht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [NB_W-1:0]   divisor,
  output logic              done,
  output logic [NB_W-1:0]   rem
);

  localparam int BitsPerStep = 4;
  localparam int Steps       = ADDR_W / BitsPerStep;
  localparam int CntW        = $clog2(Steps);

  logic              busy_r;
  logic              done_r;
  logic [CntW-1:0]   cnt_r;
  logic [NB_W-1:0]   rem_r;
  logic [NB_W-1:0]   rem_nxt;
  logic [NB_W-1:0]   div_r;
  logic [ADDR_W-1:0] sh_r;

  // Long division of the address, four bits at a time from the top. The
  // running remainder stays below the divisor, so one subtract per bit does.
  always_comb begin
    logic [NB_W:0] t;
    rem_nxt = rem_r;
    for (int b = 0; b < BitsPerStep; b++) begin
      t = {rem_nxt, sh_r[ADDR_W-1-b]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[NB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= sh_r << BitsPerStep;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/bht_store.sv */
`timescale 1ns / 1ps

module bht_store import bht_pkg::*; #(
  parameter int MAX_BACKENDS = DEF_MAX_BACKENDS,
  localparam int IdxW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            re,
  input  logic [IdxW-1:0] raddr,
  output entry_t          rdata,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  entry_t          wdata
);

  entry_t mem [MAX_BACKENDS];
  logic   valid_r [MAX_BACKENDS];
  entry_t rd_data_r;
  logic   rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Entries never written since reset read as initial mode with a zero count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BACKENDS; i++) begin
        valid_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= valid_r[raddr];
      end
    end
  end

  always_comb begin
    rdata.address = rd_data_r.address;
    rdata.mode    = rd_vld_r ? rd_data_r.mode : MODE_INITIAL;
    rdata.count   = rd_vld_r ? rd_data_r.count : '0;
  end

endmodule

/* hw/rtl/backend_health_table.sv */
`timescale 1ns / 1ps

// Backend health table: one result beat per input beat, taken one item at a
// time. Entries live in a single-port-read store with a registered read;
// heartbeat, query reply and tick read an entry and write it back, load
// only writes, and select only reads. Load, and a load, heartbeat or query
// reply whose index is not below the entry count, go from dispatch straight
// to the result; heartbeat and query reply read the entry, then write it
// back. Tick and activation walk the entries in use one per cycle through
// the store's read port; an activation stops at its first match. Select: a
// remainder unit, four address bits a cycle, computes the address modulo
// the entry count before the read. A new item is taken once the previous
// result sits in the output register. Reset returns every entry to initial
// mode with a zero count at once; addresses hold nothing until loaded.
module backend_health_table import bht_pkg::*; #(
  parameter int MAX_BACKENDS = DEF_MAX_BACKENDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bht_in_if.sink                in_ch,
  bht_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IdxW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_RMW      = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_REM      = 7'b0010000,
    S_SEL      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NB_W-1:0]     nb_r;
  logic [MISSED_W-1:0] mm_r;

  action_t             act_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                init_r;
  logic                ack_r;

  logic [IdxW-1:0]     scan_r, scan_nxt;
  result_t             res_r, res_nxt;
  result_t             out_r;
  logic                out_valid_r;

  logic                in_fire;
  logic                out_load;
  logic                cfg_wr;
  logic [NB_W-1:0]     n_eff;
  logic                idx_ok;
  logic [IdxW-1:0]     idx_e;
  logic                last;

  logic                st_re, st_we;
  logic [IdxW-1:0]     st_raddr, st_waddr;
  entry_t              st_rdata, st_wdata;
  entry_t              tick_e;

  logic                rem_start, rem_done;
  logic [NB_W-1:0]     rem_val;

  bht_store #(.MAX_BACKENDS(MAX_BACKENDS)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata)
  );

  bht_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (addr_r),
    .divisor  (n_eff),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= NB_W'(1);
      mm_r <= MISSED_W'(3);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_NUM_BACKENDS: nb_r <= pwdata[NB_W-1:0];
        REG_MAX_MISSED:   mm_r <= pwdata[MISSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_NUM_BACKENDS: prdata = CFG_DATA_W'(nb_r);
      REG_MAX_MISSED:   prdata = CFG_DATA_W'(mm_r);
      default:          prdata = '0;
    endcase
  end

  // Entry count in use, clamped to at least one and to the table size.
  always_comb begin
    if (nb_r == '0) begin
      n_eff = NB_W'(1);
    end else if (32'(nb_r) > MAX_BACKENDS) begin
      n_eff = NB_W'(MAX_BACKENDS);
    end else begin
      n_eff = nb_r;
    end
  end

  assign idx_ok = {1'b0, idx_r} < n_eff;
  assign idx_e  = IdxW'(idx_r);
  assign last   = (32'(scan_r) + 32'd1) == 32'(n_eff);

  // Tick update of the entry currently read.
  always_comb begin
    tick_e = st_rdata;
    if (st_rdata.mode == MODE_NORMAL && st_rdata.count != COUNT_MAX) begin
      tick_e.count = st_rdata.count + 1'b1;
    end
    if (tick_e.count > {1'b0, mm_r}) begin
      tick_e.mode = MODE_FAULT;
    end
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    res_nxt   = res_r;
    st_re     = 1'b0;
    st_raddr  = '0;
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = st_rdata;
    rem_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_nxt = '0;
        case (act_r)
          ACT_LOAD, ACT_HEARTBEAT, ACT_QUERY: begin
            if (!idx_ok) begin
              res_nxt.bad_index = 1'b1;
              state_nxt = S_DONE;
            end else if (act_r == ACT_LOAD) begin
              st_we            = 1'b1;
              st_waddr         = idx_e;
              st_wdata.address = addr_r;
              st_wdata.mode    = MODE_INITIAL;
              st_wdata.count   = '0;
              state_nxt        = S_DONE;
            end else begin
              st_re     = 1'b1;
              st_raddr  = idx_e;
              state_nxt = S_RMW;
            end
          end
          ACT_TICK, ACT_ACTIVATE: begin
            res_nxt.activation_ack = (act_r == ACT_ACTIVATE);
            st_re     = 1'b1;
            st_raddr  = '0;
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
          ACT_SELECT: begin
            rem_start = 1'b1;
            state_nxt = S_REM;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RMW: begin
        st_we    = 1'b1;
        st_waddr = idx_e;
        if (act_r == ACT_HEARTBEAT) begin
          if (st_rdata.mode == MODE_NORMAL) begin
            st_wdata.count = '0;
          end
          res_nxt.start_query = (st_rdata.mode == MODE_FAULT);
        end else if (ack_r) begin
          st_wdata.mode  = MODE_NORMAL;
          st_wdata.count = '0;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // Data for entry scan_r is here; the next entry is read meanwhile.
        if (act_r == ACT_TICK) begin
          st_we    = 1'b1;
          st_waddr = scan_r;
          st_wdata = tick_e;
          if (last) begin
            state_nxt = S_DONE;
          end else begin
            st_re    = 1'b1;
            st_raddr = scan_r + 1'b1;
            scan_nxt = scan_r + 1'b1;
          end
        end else if (st_rdata.address == addr_r) begin
          res_nxt.found     = 1'b1;
          res_nxt.index_out = INDEX_W'(scan_r);
          if (init_r) begin
            st_we          = 1'b1;
            st_waddr       = scan_r;
            st_wdata.mode  = MODE_NORMAL;
            st_wdata.count = '0;
          end
          state_nxt = S_DONE;
        end else if (last) begin
          state_nxt = S_DONE;
        end else begin
          st_re    = 1'b1;
          st_raddr = scan_r + 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_REM: begin
        if (rem_done) begin
          st_re             = 1'b1;
          st_raddr          = IdxW'(rem_val);
          res_nxt.index_out = INDEX_W'(rem_val);
          state_nxt         = S_SEL;
        end
      end
      S_SEL: begin
        res_nxt.entry_normal = (st_rdata.mode == MODE_NORMAL);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= action_t'(in_ch.action);
      idx_r  <= in_ch.index;
      addr_r <= in_ch.address;
      init_r <= in_ch.message_initial;
      ack_r  <= in_ch.ack_ok;
    end
    scan_r <= scan_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.index_out      = out_r.index_out;
  assign out_ch.found          = out_r.found;
  assign out_ch.entry_normal   = out_r.entry_normal;
  assign out_ch.start_query    = out_r.start_query;
  assign out_ch.activation_ack = out_r.activation_ack;
  assign out_ch.bad_index      = out_r.bad_index;

`ifndef SYNTHESIS
  // The scan reads one entry ahead of the one it writes back.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_we && st_re) |-> (st_waddr != st_raddr))
    else $error("store read and write hit the same entry");

  a_rem_in_select: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_REM))
    else $error("remainder finished outside a select");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DISPATCH))
    else $error("accepted beat not dispatched");
`endif

endmodule
